// ----- src/epsd_pkg.sv -----
// Package for the encoder PID straight-drive controller.
// Holds the sequencer states, codes, shared multiplier widths and drive constants.
// No dependencies; imported by epsd_mul, encoder_pid_straight_drive and the bench.
package epsd_pkg;

  // shared multiplier: signed 27 x signed 25 (gains enter zero-extended)
  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [6:0]  MIN_DRIVE    = 7'd5;
  localparam logic [6:0]  MAX_DRIVE    = 7'd100;
  localparam logic [2:0]  SETTLE_LIMIT = 3'd5;
  localparam logic [2:0]  SETTLE_MAX   = 3'd7;
  // pid clip level, 100 in Q.17
  localparam logic [23:0] PID_MAX      = 24'd13107200;
  // floor(x/100) == (x*5243) >> 19 for x below 12800
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam logic [60:0] ITERM_SAT    = 61'h1000_0000_0000_0000;
  localparam logic [47:0] SUM_MAX      = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SUM_MIN      = 48'h8000_0000_0000;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_CNT_PER_IN  = 3'd3,
    REG_SETTLE_THR  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TGT_MUL,
    ST_TGT_FIN,
    ST_ERR,
    ST_SUM,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_ILO,
    ST_MUL_IHI,
    ST_ICLIP,
    ST_IADD,
    ST_CLIP,
    ST_SCALE,
    ST_RECIP,
    ST_DRIVE,
    ST_EMIT
  } state_t;

endpackage

// ----- src/epsd_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on epsd_pkg for operand and product widths.
module epsd_mul
  import epsd_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic signed [MUL_B_W-1:0] op_b,
  output logic signed [PROD_W-1:0]  prod_r
);

  // operands sign-extended to full width before the multiply
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

// ----- src/encoder_pid_straight_drive.sv -----
// Top level of the encoder PID straight-drive controller.
// Depends on epsd_pkg and the shared multiplier epsd_mul.
//
// Usage:
//  Input stream (in_*): one word per item. in_tuser is the opcode (start or
//  tick); in_tdata carries distance and speed for a start, the two encoder
//  positions for a tick. Output stream (out_*): exactly one word per input
//  word, in order: the two drive levels, tuser = drives rewritten, tlast =
//  move finished (brake).
//  Config port (cfg_*): always ready; registers 0..4 are the three Q8.16
//  gains, degrees per inch and the settle threshold. Other indexes ignored.
//  Write only while the block is idle.
//  Flow: one item at a time; in_tready is high only in the idle state. A
//  start goes through the two target states to emit; a tick during a move
//  goes through the error, sum, multiply, integral, clip, scale, reciprocal
//  and drive states to emit; a tick while idle goes straight to emit. A tick
//  uses the single 27x25 multiplier six times in sequence (P, D, two halves of
//  the integral product, speed scale, divide-by-100 reciprocal).
//  The output register parts the two sides: a new word is accepted while a
//  result waits; a finished item then holds in the emit state until the
//  receiver takes the old word.
//  Reset (rst_n low, synchronous): idle, held drives zero, registers at
//  defaults (gain_prop 1.0, 30 degrees per inch, threshold 20).
module encoder_pid_straight_drive
  import epsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [23:0] travel_distance, [30:24] base_speed, [51:31] left_position,
  // [72:52] right_position, [79:73] zero
  input  logic [79:0] in_tdata,
  // [0] opcode
  input  logic [0:0]  in_tuser,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [6:0] left_drive, [13:7] right_drive, [15:14] zero
  output logic [15:0] out_tdata,
  // [0] drive_updated
  output logic [0:0]  out_tuser,
  // move_done
  output logic        out_tlast,
  // config write port
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // ---------------------------------------------------------------- config
  logic [23:0]        gp_r, gi_r, gd_r, cpi_r;
  logic signed [16:0] thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r  <= 24'd65536;
      gi_r  <= 24'd0;
      gd_r  <= 24'd0;
      cpi_r <= 24'd1966080;
      thr_r <= 17'sd20;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_GAIN_PROP:  gp_r  <= cfg_data;
        REG_GAIN_INTEG: gi_r  <= cfg_data;
        REG_GAIN_DERIV: gd_r  <= cfg_data;
        REG_CNT_PER_IN: cpi_r <= cfg_data;
        REG_SETTLE_THR: thr_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  state_t state_r, state_nxt;

  // captured input word
  logic signed [23:0] dist_r, dist_nxt;
  logic [6:0]         spd_r, spd_nxt;
  logic signed [20:0] lp_r, lp_nxt, rp_r, rp_nxt;

  // controller state
  logic signed [24:0] tgt_r, tgt_nxt;
  logic signed [25:0] last_r, last_nxt;
  logic signed [47:0] sum_r, sum_nxt;
  logic [6:0]         hs_r, hs_nxt;
  logic [2:0]         sc_r, sc_nxt;
  logic [6:0]         lh_r, lh_nxt, rh_r, rh_nxt;
  logic               moving_r, moving_nxt;

  // per-tick working registers
  logic signed [25:0] e2_r, e2_nxt;
  logic               diff_r, diff_nxt;
  logic               hit_r, hit_nxt;
  logic [47:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [47:0]        ilo_r, ilo_nxt;
  logic [60:0]        iprod_r, iprod_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic               pos_r, pos_nxt;
  logic [23:0]        pidc_r, pidc_nxt;

  // pending result and output register
  logic [6:0]         res_l_r, res_l_nxt, res_r_r, res_r_nxt;
  logic               res_upd_r, res_upd_nxt, res_done_r, res_done_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [6:0]         out_l_r, out_l_nxt, out_rr_r, out_rr_nxt;
  logic               out_upd_r, out_upd_nxt, out_done_r, out_done_nxt;

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;

  epsd_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  // combinational temporaries
  logic signed [PROD_W-1:0] tgt_adj;
  logic signed [24:0]       tgt_new;
  logic signed [25:0]       two_tgt, lr_sum;
  logic signed [48:0]       sum2;
  logic signed [49:0]       s2, s2_rnd;
  logic signed [48:0]       ns;
  logic signed [17:0]       thr_x2;
  logic [47:0]              hi_p;
  logic [60:0]              isum;
  logic [7:0]               q;
  logic [6:0]               drv;
  logic [2:0]               sc_new;
  logic [6:0]               lh_new;

  function automatic logic [6:0] clamp_drive(input logic [7:0] v);
    logic [6:0] r;
    if (v < 8'(MIN_DRIVE)) begin
      r = MIN_DRIVE;
    end else if (v > 8'(MAX_DRIVE)) begin
      r = MAX_DRIVE;
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_rr_r, out_l_r};
  assign out_tuser  = out_upd_r;
  assign out_tlast  = out_done_r;

  always_comb begin
    state_nxt    = state_r;
    dist_nxt     = dist_r;
    spd_nxt      = spd_r;
    lp_nxt       = lp_r;
    rp_nxt       = rp_r;
    tgt_nxt      = tgt_r;
    last_nxt     = last_r;
    sum_nxt      = sum_r;
    hs_nxt       = hs_r;
    sc_nxt       = sc_r;
    lh_nxt       = lh_r;
    rh_nxt       = rh_r;
    moving_nxt   = moving_r;
    e2_nxt       = e2_r;
    diff_nxt     = diff_r;
    hit_nxt      = hit_r;
    mag_nxt      = mag_r;
    neg_nxt      = neg_r;
    ilo_nxt      = ilo_r;
    iprod_nxt    = iprod_r;
    acc_nxt      = acc_r;
    pos_nxt      = pos_r;
    pidc_nxt     = pidc_r;
    res_l_nxt    = res_l_r;
    res_r_nxt    = res_r_r;
    res_upd_nxt  = res_upd_r;
    res_done_nxt = res_done_r;
    out_l_nxt    = out_l_r;
    out_rr_nxt   = out_rr_r;
    out_upd_nxt  = out_upd_r;
    out_done_nxt = out_done_r;
    out_valid_nxt = out_valid_r;
    mul_a        = '0;
    mul_b        = '0;

    tgt_adj = '0;
    tgt_new = '0;
    two_tgt = {tgt_r, 1'b0};
    lr_sum  = 26'(lp_r) + 26'(rp_r);
    sum2    = {sum_r, 1'b0};
    s2      = 50'(sum2) + 50'(e2_r);
    // truncate toward zero before halving
    s2_rnd  = s2 + $signed({49'd0, s2[49]});
    ns      = s2_rnd[49:1];
    thr_x2  = {thr_r, 1'b0};
    hi_p    = prod_r[47:0];
    isum    = 61'({hi_p[35:0], 24'd0}) + 61'(ilo_r);
    q       = prod_r[26:19];
    drv     = pos_r ? clamp_drive(q) : MIN_DRIVE;
    sc_new  = (hit_r && (sc_r != SETTLE_MAX)) ? sc_r + 3'd1 : sc_r;
    lh_new  = diff_r ? drv : lh_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          dist_nxt = in_tdata[23:0];
          spd_nxt  = in_tdata[30:24];
          lp_nxt   = in_tdata[51:31];
          rp_nxt   = in_tdata[72:52];
          if (op_t'(in_tuser) == OP_START) begin
            state_nxt = ST_TGT_MUL;
          end else if (moving_r) begin
            state_nxt = ST_ERR;
          end else begin
            // tick with no move running: repeat held drives
            res_l_nxt    = lh_r;
            res_r_nxt    = rh_r;
            res_upd_nxt  = 1'b0;
            res_done_nxt = 1'b0;
            state_nxt    = ST_EMIT;
          end
        end
      end
      ST_TGT_MUL: begin
        mul_a     = 27'(dist_r);
        mul_b     = {1'b0, cpi_r};
        state_nxt = ST_TGT_FIN;
      end
      ST_TGT_FIN: begin
        // divide by 2^24 toward zero
        tgt_adj      = prod_r + (prod_r[PROD_W-1] ? PROD_W'(24'hFFFFFF) : '0);
        tgt_new      = tgt_adj[48:24];
        tgt_nxt      = tgt_new;
        last_nxt     = {tgt_new, 1'b0};
        sum_nxt      = '0;
        sc_nxt       = '0;
        hs_nxt       = spd_r;
        lh_nxt       = clamp_drive({1'b0, spd_r});
        rh_nxt       = clamp_drive({1'b0, spd_r});
        moving_nxt   = 1'b1;
        res_l_nxt    = clamp_drive({1'b0, spd_r});
        res_r_nxt    = clamp_drive({1'b0, spd_r});
        res_upd_nxt  = 1'b1;
        res_done_nxt = 1'b0;
        state_nxt    = ST_EMIT;
      end
      ST_ERR: begin
        e2_nxt    = two_tgt - lr_sum;
        diff_nxt  = (lp_r != rp_r);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (ns[48] != ns[47]) begin
          sum_nxt = ns[48] ? SUM_MIN : SUM_MAX;
        end else begin
          sum_nxt = ns[47:0];
        end
        hit_nxt   = (e2_r <= 26'(thr_x2));
        state_nxt = ST_MUL_P;
      end
      ST_MUL_P: begin
        mul_a     = 27'(e2_r);
        mul_b     = {1'b0, gp_r};
        mag_nxt   = sum_r[47] ? 48'(-sum_r) : 48'(sum_r);
        neg_nxt   = sum_r[47];
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        mul_a     = 27'(e2_r) - 27'(last_r);
        mul_b     = {1'b0, gd_r};
        acc_nxt   = 64'(prod_r);
        last_nxt  = e2_r;
        state_nxt = ST_MUL_ILO;
      end
      ST_MUL_ILO: begin
        mul_a     = 27'(mag_r[23:0]);
        mul_b     = {1'b0, gi_r};
        acc_nxt   = acc_r + 64'(prod_r);
        state_nxt = ST_MUL_IHI;
      end
      ST_MUL_IHI: begin
        mul_a     = 27'(mag_r[47:24]);
        mul_b     = {1'b0, gi_r};
        ilo_nxt   = prod_r[47:0];
        state_nxt = ST_ICLIP;
      end
      ST_ICLIP: begin
        // integral product saturates at 2^60
        if ((|hi_p[47:36]) || (isum > ITERM_SAT)) begin
          iprod_nxt = ITERM_SAT;
        end else begin
          iprod_nxt = isum;
        end
        state_nxt = ST_IADD;
      end
      ST_IADD: begin
        if (neg_r) begin
          acc_nxt = acc_r - $signed(64'({iprod_r, 1'b0}));
        end else begin
          acc_nxt = acc_r + $signed(64'({iprod_r, 1'b0}));
        end
        state_nxt = ST_CLIP;
      end
      ST_CLIP: begin
        pos_nxt   = (acc_r > 64'sd0);
        pidc_nxt  = (acc_r > $signed(64'(PID_MAX))) ? PID_MAX : acc_r[23:0];
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        mul_a     = 27'(hs_r);
        mul_b     = {1'b0, pidc_r};
        state_nxt = ST_RECIP;
      end
      ST_RECIP: begin
        mul_a     = 27'(prod_r[30:17]);
        mul_b     = 25'(RECIP_100);
        state_nxt = ST_DRIVE;
      end
      ST_DRIVE: begin
        sc_nxt = sc_new;
        if (sc_new > SETTLE_LIMIT) begin
          // settled: brake and end the move
          moving_nxt   = 1'b0;
          lh_nxt       = '0;
          rh_nxt       = '0;
          res_l_nxt    = '0;
          res_r_nxt    = '0;
          res_upd_nxt  = 1'b1;
          res_done_nxt = 1'b1;
        end else begin
          lh_nxt       = lh_new;
          rh_nxt       = diff_r ? drv : rh_r;
          res_l_nxt    = lh_new;
          res_r_nxt    = diff_r ? drv : rh_r;
          res_upd_nxt  = diff_r;
          res_done_nxt = 1'b0;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_l_nxt     = res_l_r;
          out_rr_nxt    = res_r_r;
          out_upd_nxt   = res_upd_r;
          out_done_nxt  = res_done_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tgt_r       <= '0;
      last_r      <= '0;
      sum_r       <= '0;
      hs_r        <= '0;
      sc_r        <= '0;
      lh_r        <= '0;
      rh_r        <= '0;
      moving_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tgt_r       <= tgt_nxt;
      last_r      <= last_nxt;
      sum_r       <= sum_nxt;
      hs_r        <= hs_nxt;
      sc_r        <= sc_nxt;
      lh_r        <= lh_nxt;
      rh_r        <= rh_nxt;
      moving_r    <= moving_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    dist_r     <= dist_nxt;
    spd_r      <= spd_nxt;
    lp_r       <= lp_nxt;
    rp_r       <= rp_nxt;
    e2_r       <= e2_nxt;
    diff_r     <= diff_nxt;
    hit_r      <= hit_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    ilo_r      <= ilo_nxt;
    iprod_r    <= iprod_nxt;
    acc_r      <= acc_nxt;
    pos_r      <= pos_nxt;
    pidc_r     <= pidc_nxt;
    res_l_r    <= res_l_nxt;
    res_r_r    <= res_r_nxt;
    res_upd_r  <= res_upd_nxt;
    res_done_r <= res_done_nxt;
    out_l_r    <= out_l_nxt;
    out_rr_r   <= out_rr_nxt;
    out_upd_r  <= out_upd_nxt;
    out_done_r <= out_done_nxt;
  end

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for encoder_pid_straight_drive: a directed table, then random moves.
// Holds its own copy of the straight-drive PID controller and compares every result word.
// Depends on epsd_pkg and the RTL top level only.
module tb;
  import epsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one result word, in the order the fields appear on the result stream
  typedef struct packed {
    logic [6:0] left;
    logic [6:0] right;
    logic       upd;
    logic       done;
  } drive_t;

  // one row of the directed table; fixed marks a row whose result is typed in
  typedef struct packed {
    op_t         op;
    logic [23:0] dist_in;
    logic [6:0]  spd;
    logic [20:0] lp;
    logic [20:0] rp;
    logic        fixed;
    drive_t      want;
  } dir_row_t;

  localparam int     N_DIR       = 23;
  localparam int     QUIET_LIMIT = 4000;   // cycles with no word moving on any port
  localparam int     DRAIN_WAIT  = 30;     // settle time after the last result word, before config is touched
  localparam int     PHASES      = 8;
  localparam int     PHASE_ITEMS = 113;
  localparam logic [2:0] REG_SPARE = 3'd7; // no register behind this index
  localparam longint SUM_TOP     = 64'sh7FFF_FFFF_FFFF;
  localparam longint ISAT        = 64'sh1000_0000_0000_0000;
  localparam longint PID_TOP     = 64'sd13107200;  // 100 in Q.17
  localparam longint POS_TOP     = 64'sd1048575;

  // defaults: gain 1.0, 30 deg/in, threshold 20. Typed results assume these.
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // tick straight after reset: held drives are zero, nothing rewritten
    '{OP_TICK,  24'd0,       7'd0,   21'd0,       21'd0,       1'b1, '{7'd0,   7'd0,   1'b0, 1'b0}},
    // largest distance at full speed
    '{OP_START, 24'h7FFFFF,  7'd100, 21'd0,       21'd0,       1'b1, '{7'd100, 7'd100, 1'b1, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'h100000,  21'h0FFFFF,  1'b0, '{7'd0,   7'd0,   1'b0, 1'b0}},
    // equal positions at the top of the range: drives held
    '{OP_TICK,  24'd0,       7'd0,   21'h0FFFFF,  21'h0FFFFF,  1'b0, '{7'd0,   7'd0,   1'b0, 1'b0}},
    // restart mid-move, most negative distance, zero speed clamps up to 5
    '{OP_START, 24'h800000,  7'd0,   21'd0,       21'd0,       1'b1, '{7'd5,   7'd5,   1'b1, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'h0FFFFF,  21'h100000,  1'b0, '{7'd0,   7'd0,   1'b0, 1'b0}},
    // zero distance: every tick at rest counts as settled
    '{OP_START, 24'd0,       7'd3,   21'd0,       21'd0,       1'b1, '{7'd5,   7'd5,   1'b1, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'd0,       21'd0,       1'b1, '{7'd5,   7'd5,   1'b0, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'd0,       21'd0,       1'b1, '{7'd5,   7'd5,   1'b0, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'd0,       21'd0,       1'b1, '{7'd5,   7'd5,   1'b0, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'd0,       21'd0,       1'b1, '{7'd5,   7'd5,   1'b0, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'd0,       21'd0,       1'b1, '{7'd5,   7'd5,   1'b0, 1'b0}},
    // sixth settled tick: brake and done
    '{OP_TICK,  24'd0,       7'd0,   21'd0,       21'd0,       1'b1, '{7'd0,   7'd0,   1'b1, 1'b1}},
    // tick after the move has finished
    '{OP_TICK,  24'd0,       7'd0,   21'd5,       21'd7,       1'b1, '{7'd0,   7'd0,   1'b0, 1'b0}},
    // ten inches, 300 degrees, at speed 60
    '{OP_START, 24'd2560,    7'd60,  21'd0,       21'd0,       1'b1, '{7'd60,  7'd60,  1'b1, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'd0,       21'd2,       1'b0, '{7'd0,   7'd0,   1'b0, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'd150,     21'd152,     1'b0, '{7'd0,   7'd0,   1'b0, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'd290,     21'd292,     1'b0, '{7'd0,   7'd0,   1'b0, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'd300,     21'd300,     1'b0, '{7'd0,   7'd0,   1'b0, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'd310,     21'd312,     1'b0, '{7'd0,   7'd0,   1'b0, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'd299,     21'd301,     1'b0, '{7'd0,   7'd0,   1'b0, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'd300,     21'd302,     1'b0, '{7'd0,   7'd0,   1'b0, 1'b0}},
    '{OP_TICK,  24'd0,       7'd0,   21'd301,     21'd300,     1'b0, '{7'd0,   7'd0,   1'b0, 1'b0}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  // controller copy: registers
  longint kp, ki, kd, cpi, thr;
  // controller copy: move state
  longint     tgt_deg, prev_err2, integ_sum;
  logic [6:0] spd_held, left_cmd, right_cmd;
  int         settle_n;
  bit         in_motion;

  drive_t drive_q [$];     // expected result words, oldest first
  drive_t seen, want;
  int     fail_cnt = 0;
  int     quiet_cycles = 0;
  int     sender_idle_pct = 0;
  int     sink_stall_pct = 0;

  encoder_pid_straight_drive u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [6:0] clamp_pct(longint v);
    if (v < longint'(MIN_DRIVE)) return MIN_DRIVE;
    if (v > longint'(MAX_DRIVE)) return MAX_DRIVE;
    return v[6:0];
  endfunction

  function automatic logic [20:0] clip_pos(longint v);
    if (v > POS_TOP) return POS_TOP[20:0];
    if (v < -POS_TOP - 1) return 21'h100000;
    return v[20:0];
  endfunction

  // Advances the controller copy by one accepted word and returns the drive word it gives.
  function automatic drive_t predict_drive(op_t op, logic [23:0] dist_f, logic [6:0] spd_f,
                                           logic [20:0] lp_f, logic [20:0] rp_f);
    drive_t     res;
    longint     lp, rp, e2, ns, pterm, dterm, iterm, pid, mag, prod;
    logic [6:0] lvl;
    logic       upd;
    if (op == OP_START) begin
      // target truncates toward zero, same as the signed divide here
      tgt_deg   = (longint'(signed'(dist_f)) * cpi) / (64'sd1 <<< 24);
      prev_err2 = 2 * tgt_deg;
      integ_sum = 0;
      settle_n  = 0;
      spd_held  = spd_f;
      left_cmd  = clamp_pct(longint'(spd_f));
      right_cmd = left_cmd;
      in_motion = 1'b1;
      res = '{left_cmd, right_cmd, 1'b1, 1'b0};
      return res;
    end
    if (!in_motion) begin
      res = '{left_cmd, right_cmd, 1'b0, 1'b0};
      return res;
    end
    lp = longint'(signed'(lp_f));
    rp = longint'(signed'(rp_f));
    // error with one fractional bit
    e2 = 2 * tgt_deg - (lp + rp);
    ns = (2 * integ_sum + e2) / 2;
    if (ns > SUM_TOP) ns = SUM_TOP;
    if (ns < -SUM_TOP - 1) ns = -SUM_TOP - 1;
    integ_sum = ns;
    pterm = e2 * kp;
    dterm = (e2 - prev_err2) * kd;
    prev_err2 = e2;
    mag = (integ_sum < 0) ? -integ_sum : integ_sum;
    if (ki != 0 && mag > ISAT / ki) prod = ISAT;
    else prod = mag * ki;
    iterm = 2 * prod;
    if (integ_sum < 0) iterm = -iterm;
    pid = pterm + dterm + iterm;
    if (pid > PID_TOP) pid = PID_TOP;
    upd = 1'b0;
    // equal positions leave the drives alone but the settle check still runs
    if (lp != rp) begin
      if (pid <= 0) lvl = MIN_DRIVE;
      else lvl = clamp_pct((longint'(spd_held) * pid) / PID_TOP);
      left_cmd  = lvl;
      right_cmd = lvl;
      upd = 1'b1;
    end
    if (e2 <= 2 * thr && settle_n < int'(SETTLE_MAX)) settle_n++;
    if (settle_n > int'(SETTLE_LIMIT)) begin
      in_motion = 1'b0;
      left_cmd  = '0;
      right_cmd = '0;
      res = '{7'd0, 7'd0, 1'b1, 1'b1};
      return res;
    end
    res = '{left_cmd, right_cmd, upd, 1'b0};
    return res;
  endfunction

  // Offers one input word after a random idle gap and predicts its result once accepted.
  // A word that follows straight on keeps tvalid high, so it is never dropped and raised
  // in the same step.
  task automatic send_word(op_t op, logic [23:0] dist_w, logic [6:0] spd, logic [20:0] lp,
                           logic [20:0] rp, logic fixed, drive_t typed);
    int     gap;
    drive_t pred;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, rp, lp, spd, dist_w};
    do @(posedge clk); while (!in_tready);
    pred = predict_drive(op, dist_w, spd, lp, rp);
    drive_q.push_back(fixed ? typed : pred);
  endtask

  // Register write; cfg_valid is left high so back-to-back writes need no second assignment.
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GAIN_PROP:  kp  = longint'(val);
      REG_GAIN_INTEG: ki  = longint'(val);
      REG_GAIN_DERIV: kd  = longint'(val);
      REG_CNT_PER_IN: cpi = longint'(val);
      REG_SETTLE_THR: thr = longint'(signed'(val[16:0]));
      default: ;
    endcase
  endtask

  // Register set for phase p: defaults, both extremes, then typical and raw random mixes.
  task automatic load_settings(int p);
    logic [23:0] v [5];
    bit          raw;
    case (p)
      0: v = '{24'd65536, 24'd0, 24'd0, 24'd1966080, 24'd20};
      1: v = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h00FFFF};
      // threshold -65536 with junk above bit 16
      2: v = '{24'd0, 24'd0, 24'd0, 24'd0, 24'hFF0000};
      default: begin
        raw = (p >= 4);
        v[0] = (raw && $urandom_range(1)) ? 24'($urandom) : 24'($urandom_range(196608, 32768));
        v[1] = (raw && $urandom_range(1)) ? 24'($urandom) : 24'($urandom_range(2048));
        v[2] = (raw && $urandom_range(1)) ? 24'($urandom) : 24'($urandom_range(262144));
        v[3] = (raw && $urandom_range(1)) ? 24'($urandom)
                                          : 24'($urandom_range(3932160, 655360));
        v[4] = (raw && $urandom_range(1)) ? 24'($urandom) : 24'($urandom_range(60));
      end
    endcase
    write_reg(REG_GAIN_PROP,  v[0]);
    write_reg(REG_GAIN_INTEG, v[1]);
    write_reg(REG_GAIN_DERIV, v[2]);
    write_reg(REG_CNT_PER_IN, v[3]);
    write_reg(REG_SETTLE_THR, v[4]);
    write_reg(REG_SPARE,      24'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed moves (start, ticks closing on the target, settle ticks), some cut
  // short by a fresh start, and about a fifth raw noise words.
  task automatic run_random(int quota);
    int          sent, nt, i;
    longint      tgt, base, lpos, rpos;
    logic [23:0] dist_w;
    drive_t      none;
    none = '0;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 20) begin
        send_word(op_t'($urandom_range(1)), 24'($urandom), 7'($urandom_range(100)),
                  21'($urandom), 21'($urandom), 1'b0, none);
        sent++;
      end else begin
        if ($urandom_range(9) == 0) dist_w = 24'($urandom);
        else dist_w = 24'($urandom_range(8191) - 4096);
        // unused position fields carry junk on a start
        send_word(OP_START, dist_w, 7'($urandom_range(100)), 21'($urandom), 21'($urandom),
                  1'b0, none);
        sent++;
        tgt = tgt_deg;
        nt  = $urandom_range(20, 3);
        for (i = 1; i <= nt + 8 && sent < quota; i++) begin
          if ($urandom_range(99) < 3) break;
          base = tgt * ((i < nt) ? i : nt) / nt;
          lpos = base + longint'($urandom_range(8)) - 4;
          rpos = lpos + longint'($urandom_range(4)) - 2;
          send_word(OP_TICK, 24'($urandom), 7'($urandom_range(100)), clip_pos(lpos),
                    clip_pos(rpos), 1'b0, none);
          sent++;
        end
      end
    end
  endtask

  // Waits for every expected word, then lets the block settle before config is touched.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Result side: random stall, and every accepted word checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.left  = out_tdata[6:0];
      seen.right = out_tdata[13:7];
      seen.upd   = out_tuser[0];
      seen.done  = out_tlast;
      if (drive_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result word: left %0d right %0d upd %b done %b",
                   seen.left, seen.right, seen.upd, seen.done);
      end else begin
        want = drive_q.pop_front();
        if (seen !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display({"mismatch: expected left %0d right %0d upd %b done %b, ",
                      "got left %0d right %0d upd %b done %b"},
                     want.left, want.right, want.upd, want.done,
                     seen.left, seen.right, seen.upd, seen.done);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: count cycles in which no word moves on any port.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("encoder_pid_straight_drive regression: fail");
    $finish;
  end

  initial begin
    int p, r;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_START;
    cfg_valid <= 1'b0;
    cfg_index <= REG_GAIN_PROP;
    cfg_data  <= '0;
    // controller copy at its reset values
    kp = 65536; ki = 0; kd = 0; cpi = 1966080; thr = 20;
    tgt_deg = 0; prev_err2 = 0; integ_sum = 0;
    spd_held = '0; left_cmd = '0; right_cmd = '0;
    settle_n = 0; in_motion = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset defaults, no idling
    for (r = 0; r < N_DIR; r++)
      send_word(DIR_ROWS[r].op, DIR_ROWS[r].dist_in, DIR_ROWS[r].spd, DIR_ROWS[r].lp,
                DIR_ROWS[r].rp, DIR_ROWS[r].fixed, DIR_ROWS[r].want);
    drain();

    // random phases: new register set each time, idling pattern cycling through
    // none, sender idle, receiver stalling, both lightly
    for (p = 0; p < PHASES; p++) begin
      load_settings(p);
      case (p % 4)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 74; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 74; end
        default: begin sender_idle_pct = 16; sink_stall_pct = 16; end
      endcase
      run_random(PHASE_ITEMS);
      drain();
    end

    if (fail_cnt == 0 && drive_q.size() == 0)
      $display("encoder_pid_straight_drive regression: pass");
    else
      $display("encoder_pid_straight_drive regression: fail");
    $finish;
  end

endmodule

// ----- encoder_pid_straight_drive.f -----
src/epsd_pkg.sv
src/epsd_mul.sv
src/encoder_pid_straight_drive.sv
sim/tb.sv
